// ----- design/ensw_pkg.sv -----
// shared types and constants for the edge normalized window sum unit
// no dependencies; the top level and ensw_cell refer to this package by scoped names
`default_nettype none

package ensw_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int SMOOTH_W       = 22;
    localparam int RADIUS_W       = 6;
    localparam int MAX_RADIUS_DEF = 32;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                seq_end;
    } ensw_sample_t;

    typedef struct packed {
        logic [SMOOTH_W-1:0] smoothed;
        logic                out_last;
    } ensw_result_t;

endpackage

`default_nettype wire

// ----- design/edge_normalized_window_sum_unit.sv -----
// top level of the edge normalized boxcar window sum
// depends on ensw_pkg, ensw_cell (delay line) and ensw_div (edge normalization)
`default_nettype none

// Boxcar moving sum over a stream of unsigned samples split into sequences by seq_end.
// With radius r (0 acts as 1, above MAX_RADIUS acts as MAX_RADIUS) the half-width is
// h = r-1 and the window W = 2h+1; each result is the window sum clipped to the sequence,
// scaled to W*sum/cnt rounded half up where the window is clipped. Results lag the input
// by h samples and the seq_end sample flushes the rest, the final one marked out_last.
// Samples sit in a row of 2*MAX_RADIUS-1 delay cells whose injection point follows the
// radius, so the expiring sample always leaves at cell zero. A request is accepted only in
// ST_IDLE; a full-window result loads from ST_RES, a clipped result goes through the
// bit-serial divider in ST_DIV, and each flushed position first steps the delay line
// in ST_ADV. Writing the radius restarts
// the current sequence. The output register lets a result wait while the next request
// is taken.
module edge_normalized_window_sum_unit #(
    parameter int MAX_RADIUS = ensw_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output      logic                          sample_stall,
    input  wire ensw_pkg::ensw_sample_t        sample_data,
    output      logic                          result_valid,
    input  wire logic                          result_stall,
    output      ensw_pkg::ensw_result_t        result_data,
    input  wire logic                          radius_we,
    input  wire logic [ensw_pkg::RADIUS_W-1:0] radius_wdata
);

    localparam int DEPTH = 2 * MAX_RADIUS;
    localparam int NCELL = DEPTH - 1;
    localparam int CNT_W = $clog2(DEPTH) + 1;
    localparam int SUM_W = ensw_pkg::SAMPLE_W + $clog2(DEPTH);
    localparam int NUM_W = SUM_W + CNT_W + 1;
    localparam int EXT_W = ensw_pkg::RADIUS_W + CNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADV  = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [ensw_pkg::RADIUS_W-1:0] radius_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [CNT_W-1:0]              seen_reg;
    logic [CNT_W-1:0]              flush_left_reg;
    logic [CNT_W-1:0]              flush_left_next;
    logic                          result_valid_reg;
    ensw_pkg::ensw_result_t        result_data_reg;

    logic [SUM_W-1:0]              t_sum_reg;
    logic [CNT_W-1:0]              t_cnt_reg;
    logic                          res_last_reg;

    logic [EXT_W-1:0]              rad_ext;
    logic [EXT_W-1:0]              rad_eff;
    logic [CNT_W-1:0]              half;
    logic [CNT_W-1:0]              full;
    logic [CNT_W-1:0]              top_idx;

    logic                          accept;
    logic                          out_free;
    logic                          out_load;
    logic [SUM_W-1:0]              out_value;
    logic [CNT_W-1:0]              seen_inc;
    logic [SUM_W-1:0]              sum_add;
    logic [SUM_W-1:0]              sum_new;
    logic [CNT_W-1:0]              cnt_new;
    logic [CNT_W-1:0]              flush_cnt;
    logic                          has_norm;
    logic [CNT_W-1:0]              flush_d;
    logic                          remove;
    logic                          shift;
    logic                          div_start;
    logic                          div_busy;
    logic [NUM_W-1:0]              div_quotient;
    logic [NUM_W-1:0]              dividend;

    logic [ensw_pkg::SAMPLE_W-1:0] chain_data [NCELL];
    logic [ensw_pkg::SAMPLE_W-1:0] chain_up   [NCELL];

    // effective radius and derived window sizes
    always_comb
    begin
        rad_ext = EXT_W'(radius_reg);
        priority if (rad_ext == '0)
        begin
            rad_eff = EXT_W'(1);
        end
        else if (rad_ext > EXT_W'(MAX_RADIUS))
        begin
            rad_eff = EXT_W'(MAX_RADIUS);
        end
        else
        begin
            rad_eff = rad_ext;
        end
        half    = CNT_W'(rad_eff - EXT_W'(1));
        full    = CNT_W'({half, 1'b1});
        top_idx = CNT_W'({half, 1'b0});
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;

    // running sum update for a new sample
    always_comb
    begin
        seen_inc  = (seen_reg == CNT_W'(DEPTH)) ? seen_reg : seen_reg + CNT_W'(1);
        sum_add   = sum_reg + SUM_W'(sample_data.sample);
        sum_new   = (seen_inc > full) ? sum_add - SUM_W'(chain_data[0]) : sum_add;
        cnt_new   = (seen_inc < full) ? seen_inc : full;
        flush_cnt = (seen_inc < half) ? seen_inc : half;
        has_norm  = (seen_inc > half);
    end

    // flush step: drop the oldest sample once the clipped window shrinks past it
    always_comb
    begin
        flush_d = flush_left_reg - CNT_W'(1);
        remove  = ({1'b0, t_cnt_reg} >
                   ({1'b0, flush_d} + {1'b0, half} + (CNT_W + 1)'(1)));
    end

    assign shift = accept || (state_reg == ST_ADV);

    assign dividend = NUM_W'({full, 1'b0}) * NUM_W'(t_sum_reg) + NUM_W'(t_cnt_reg);

    // result sequencing
    always_comb
    begin
        state_next      = state_reg;
        flush_left_next = flush_left_reg;
        div_start       = 1'b0;
        out_load        = 1'b0;
        out_value       = t_sum_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (has_norm)
                    begin
                        state_next      = ST_RES;
                        flush_left_next = sample_data.seq_end ? flush_cnt : '0;
                    end
                    else if (sample_data.seq_end)
                    begin
                        state_next      = ST_ADV;
                        flush_left_next = flush_cnt;
                    end
                end
            end
            ST_ADV:
            begin
                state_next      = ST_RES;
                flush_left_next = flush_d;
            end
            ST_RES:
            begin
                if (t_cnt_reg == full)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = (flush_left_reg != '0) ? ST_ADV : ST_IDLE;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                out_value = SUM_W'(div_quotient);
                if (!div_busy && out_free)
                begin
                    out_load   = 1'b1;
                    state_next = (flush_left_reg != '0) ? ST_ADV : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            radius_reg       <= ensw_pkg::RADIUS_RESET;
            sum_reg          <= '0;
            seen_reg         <= '0;
            flush_left_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            flush_left_reg <= flush_left_next;
            if (radius_we)
            begin
                radius_reg <= radius_wdata;
                sum_reg    <= '0;
                seen_reg   <= '0;
            end
            else if (accept)
            begin
                sum_reg  <= sample_data.seq_end ? '0 : sum_new;
                seen_reg <= sample_data.seq_end ? '0 : seen_inc;
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_sum_reg    <= sum_new;
            t_cnt_reg    <= cnt_new;
            res_last_reg <= sample_data.seq_end && (half == '0);
        end
        else if (state_reg == ST_ADV)
        begin
            if (remove)
            begin
                t_sum_reg <= t_sum_reg - SUM_W'(chain_data[0]);
                t_cnt_reg <= t_cnt_reg - CNT_W'(1);
            end
            res_last_reg <= (flush_left_reg == CNT_W'(1));
        end
        if (out_load)
        begin
            result_data_reg.smoothed <= ensw_pkg::SMOOTH_W'(out_value);
            result_data_reg.out_last <= res_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // delay line, oldest sample of a full window sits in cell zero
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        if (i == NCELL - 1)
        begin : g_end
            assign chain_up[i] = '0;
        end
        else
        begin : g_mid
            assign chain_up[i] = chain_data[i+1];
        end

        ensw_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .shift    (shift),
            .top      (top_idx),
            .fill     (sample_data.sample),
            .upstream (chain_up[i]),
            .data     (chain_data[i])
        );
    end

    ensw_div #(
        .NUM_W (NUM_W),
        .DVS_W (CNT_W + 1)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  ({t_cnt_reg, 1'b0}),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

endmodule

`default_nettype wire

// ----- design/ensw_cell.sv -----
// one cell of the sample delay line: holds one sample, loads from its upstream neighbor
// or takes the new sample when it is the injection point; uses ensw_pkg
`default_nettype none

module ensw_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  wire logic                          clk,
    input  wire logic                          shift,
    input  wire logic [CNT_W-1:0]              top,
    input  wire logic [ensw_pkg::SAMPLE_W-1:0] fill,
    input  wire logic [ensw_pkg::SAMPLE_W-1:0] upstream,
    output      logic [ensw_pkg::SAMPLE_W-1:0] data
);

    logic [ensw_pkg::SAMPLE_W-1:0] data_reg;
    logic [ensw_pkg::SAMPLE_W-1:0] data_next;

    // the cell at the injection point starts the delay, cells below just pass along
    assign data_next = (top == CNT_W'(INDEX)) ? fill : upstream;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- design/ensw_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// used for edge normalization; no package dependencies
`default_nettype none

module ensw_div #(
    parameter int NUM_W = 29,
    parameter int DVS_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output      logic             busy,
    output      logic [NUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  rem_next;
    logic [NUM_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    trial;
    logic              q_bit;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        q_bit    = (trial >= {1'b0, dvs_reg});
        rem_next = q_bit ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // dividend bits shift out at the top while quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_edge_normalized_window_sum_unit.sv -----
`timescale 1ns / 100ps
// self-checking testbench for edge_normalized_window_sum_unit (boxcar window sum, edge scaled)
// depends on ensw_pkg and the unit's rtl; predicts each smoothed result and checks it in order

module tb_edge_normalized_window_sum_unit;

    localparam int MAX_WIN_RADIUS = ensw_pkg::MAX_RADIUS_DEF;
    localparam int HIST_DEPTH     = 2 * MAX_WIN_RADIUS;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 14;
    localparam int CYCLE_LIMIT    = 1000000;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               sample_valid = 1'b0;
    logic                               sample_stall;
    ensw_pkg::ensw_sample_t             sample_data = '0;
    logic                               result_valid;
    logic                               result_stall = 1'b0;
    ensw_pkg::ensw_result_t             result_data;
    logic                               radius_we = 1'b0;
    logic [ensw_pkg::RADIUS_W-1:0]      radius_wdata = '0;

    // predictor state
    logic [ensw_pkg::SAMPLE_W-1:0]      sample_hist [HIST_DEPTH];
    longint unsigned                    win_total;
    int unsigned                        seq_count;
    int unsigned                        hist_ptr;
    logic [ensw_pkg::RADIUS_W-1:0]      radius_reg;
    ensw_pkg::ensw_result_t             smooth_q [$];

    int                                 send_idle_pct = 0;
    int                                 stall_pct = 0;
    int                                 hold_trigger = 0;
    int                                 hold_seen = 0;
    int                                 hold_left = 0;
    int                                 mismatch_count = 0;
    int                                 cycle_count = 0;

    edge_normalized_window_sum_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .radius_we    (radius_we),
        .radius_wdata (radius_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen    <= hold_trigger;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        ensw_pkg::ensw_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (smooth_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result %0d last %0b",
                                        result_data.smoothed, result_data.out_last));
            end
            else
            begin
                want = smooth_q.pop_front();
                if (result_data.smoothed !== want.smoothed)
                    flag_mismatch($sformatf("smoothed %0d, expected %0d",
                                            result_data.smoothed, want.smoothed));
                if (result_data.out_last !== want.out_last)
                    flag_mismatch($sformatf("out_last %0b, expected %0b",
                                            result_data.out_last, want.out_last));
            end
        end
    end

    function automatic logic [ensw_pkg::SMOOTH_W-1:0] normalize(input longint unsigned total,
                                                                input int unsigned cnt,
                                                                input int unsigned full);
        longint unsigned num;
        longint unsigned den;
        if (cnt == 0)
            return '0;
        if (cnt == full)
            return ensw_pkg::SMOOTH_W'(total);
        // W*sum/cnt rounded half up, exact
        num = 64'(2 * full) * total + 64'(cnt);
        den = 64'(2 * cnt);
        return ensw_pkg::SMOOTH_W'(num / den);
    endfunction

    function automatic longint unsigned hist_back(input int unsigned cur, input int unsigned off);
        return sample_hist[(cur + HIST_DEPTH - (off % HIST_DEPTH)) % HIST_DEPTH];
    endfunction

    function automatic int unsigned half_width(input logic [ensw_pkg::RADIUS_W-1:0] r);
        int unsigned eff;
        eff = r;
        if (eff == 0)
            eff = 1;
        if (eff > MAX_WIN_RADIUS)
            eff = MAX_WIN_RADIUS;
        return eff - 1;
    endfunction

    function automatic void predict_window(input ensw_pkg::ensw_sample_t item);
        int unsigned            h;
        int unsigned            full;
        int unsigned            cur;
        int unsigned            cnt;
        int unsigned            tcnt;
        longint unsigned        tsum;
        int                     d;
        ensw_pkg::ensw_result_t res;
        h    = half_width(radius_reg);
        full = 2 * h + 1;
        cur  = hist_ptr % HIST_DEPTH;
        sample_hist[cur] = item.sample;
        hist_ptr = (cur + 1) % HIST_DEPTH;
        if (seq_count < HIST_DEPTH)
            seq_count++;
        win_total += item.sample;
        if (seq_count > full)
            win_total -= hist_back(cur, full);
        cnt = (seq_count < full) ? seq_count : full;
        if (seq_count > h)
        begin
            res.smoothed = normalize(win_total, cnt, full);
            res.out_last = item.seq_end && (h == 0);
            smooth_q.push_back(res);
        end
        if (item.seq_end)
        begin
            // flush the trailing positions, shrinking the window from the old side
            tsum = win_total;
            tcnt = cnt;
            d    = int'(h) - 1;
            if (d > int'(seq_count) - 1)
                d = int'(seq_count) - 1;
            while (d >= 0)
            begin
                while (tcnt >= 2 && int'(tcnt) - 1 > d + int'(h))
                begin
                    tsum -= hist_back(cur, tcnt - 1);
                    tcnt--;
                end
                res.smoothed = normalize(tsum, tcnt, full);
                res.out_last = (d == 0);
                smooth_q.push_back(res);
                d--;
            end
            win_total = 0;
            seq_count = 0;
        end
    endfunction

    // sender keeps valid high between back-to-back requests
    task automatic send_sample(input logic [ensw_pkg::SAMPLE_W-1:0] value, input logic seq_end);
        ensw_pkg::ensw_sample_t item;
        item.sample  = value;
        item.seq_end = seq_end;
        predict_window(item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        sample_valid <= 1'b1;
        sample_data  <= item;
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (smooth_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called with the unit drained
    task automatic write_radius(input logic [ensw_pkg::RADIUS_W-1:0] value);
        radius_we    <= 1'b1;
        radius_wdata <= value;
        @(posedge clk);
        radius_we  <= 1'b0;
        radius_reg  = value;
        win_total   = 0;
        seq_count   = 0;
    endtask

    function automatic logic [ensw_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return ensw_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [ensw_pkg::RADIUS_W-1:0] pick_radius();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ensw_pkg::RADIUS_W'(MAX_WIN_RADIUS);
            2:       return ensw_pkg::RADIUS_W'($urandom_range(MAX_WIN_RADIUS + 1, 63));
            3:       return ensw_pkg::RADIUS_W'($urandom_range(7, MAX_WIN_RADIUS - 1));
            default: return ensw_pkg::RADIUS_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic send_sequence(input int len, input logic closed);
        for (int i = 0; i < len; i++)
            send_sample(rand_sample(), closed && (i == len - 1));
    endtask

    task automatic test_reset_radius();
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(16'h5a5a, 1'b1);
        wait_drained();
    endtask

    task automatic test_edge_scaling();
        write_radius(6'd3);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample('1, 1'b0);
        send_sample(16'd7, 1'b1);
        wait_drained();
    endtask

    // sequences shorter than h+1, windows clipped on both sides
    task automatic test_short_sequences();
        write_radius(6'd4);
        send_sample(16'd3, 1'b0);
        send_sample(16'd4, 1'b1);
        send_sample(16'd9, 1'b1);
        wait_drained();
    endtask

    task automatic test_radius_extremes();
        write_radius('0);
        send_sample(16'd100, 1'b0);
        send_sample('1, 1'b1);
        wait_drained();
        write_radius(6'd63);
        send_sample('1, 1'b1);
        send_sample('1, 1'b0);
        send_sample(16'h8000, 1'b1);
        wait_drained();
        write_radius(ensw_pkg::RADIUS_W'(MAX_WIN_RADIUS));
        send_sample(16'h0001, 1'b1);
        wait_drained();
    endtask

    // radius write drops the open sequence without results
    task automatic test_radius_restart();
        write_radius(6'd5);
        send_sample(16'd11, 1'b0);
        send_sample(16'd22, 1'b0);
        send_sample(16'd33, 1'b0);
        wait_drained();
        write_radius(6'd2);
        send_sample(16'd5, 1'b0);
        send_sample(16'd6, 1'b0);
        send_sample(16'd8, 1'b1);
        wait_drained();
    endtask

    // long receiver hold-off while the sender keeps going
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_radius(6'd1);
        hold_trigger <= hold_trigger + 1;
        send_sequence(20, 1'b1);
        wait_drained();
        write_radius(6'd3);
        hold_trigger <= hold_trigger + 1;
        send_sequence(12, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_phases();
        int          sent;
        int unsigned h;
        int          cap;
        int          len;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 51;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 51;
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct     = 17;
                end
            endcase
            write_radius(pick_radius());
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                h   = half_width(radius_reg);
                cap = (int'(2 * h + 4) < PHASE_ITEMS - sent) ? int'(2 * h + 4)
                                                             : PHASE_ITEMS - sent;
                len = $urandom_range(1, cap);
                if ($urandom_range(7) == 0)
                begin
                    // broken sequence: cut off by a radius change
                    send_sequence(len, 1'b0);
                    wait_drained();
                    write_radius(pick_radius());
                end
                else
                begin
                    send_sequence(len, 1'b1);
                end
                sent += len;
            end
            wait_drained();
        end
    endtask

    initial
    begin
        win_total  = 0;
        seq_count  = 0;
        hist_ptr   = 0;
        radius_reg = ensw_pkg::RADIUS_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_radius();
        test_edge_scaling();
        test_short_sequences();
        test_radius_extremes();
        test_radius_restart();
        test_backpressure();
        test_random_phases();
        wait_drained();
        if (mismatch_count == 0 && smooth_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
